>>> sv/imm_pkg.sv
// Shared types, widths and codes for the integer matrix multiply engine.
package imm_pkg;

  localparam int MODE_W      = 2;
  localparam int ROW_W       = 6;
  localparam int COL_W       = 6;
  localparam int VALUE_W     = 16;
  localparam int PRODUCT_W   = 32;
  localparam int SIZE_W      = 7;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

  localparam int MAX_DIM_DEF   = 64;
  localparam int ELEM_BITS_DEF = 16;

  localparam logic [MODE_W-1:0] MODE_WR_LEFT  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WR_RIGHT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_COMPUTE  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic clear;
    logic issue;
  } mac_ctrl_t;

endpackage

>>> sv/imm_if.sv
// Handshake channels for input items and result items.
interface imm_in_if import imm_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [MODE_W-1:0]         mode;
  logic [ROW_W-1:0]          row;
  logic [COL_W-1:0]          col;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, mode, row, col, value, input ready);
  modport sink   (input valid, mode, row, col, value, output ready);
endinterface

interface imm_out_if import imm_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [PRODUCT_W-1:0] product;
  logic                        bad_index;

  modport source (output valid, product, bad_index, input ready);
  modport sink   (input valid, product, bad_index, output ready);
endinterface

>>> sv/integer_matrix_multiply_engine.sv
// Integer matrix multiply engine: element stores, sequencer and result register.
// Write items are accepted while idle. A compute item with valid indices runs one
// multiply-accumulate per element for dimension n in use, through the shared MAC
// and one read port per store. A compute item with a bad index skips the run and
// returns a zero product with bad_index set.
// Synchronous reset clears control and sets the size to 64; store contents are
// undefined until written.
module integer_matrix_multiply_engine import imm_pkg::*; #(
  parameter int MAX_DIM   = MAX_DIM_DEF,
  parameter int ELEM_BITS = ELEM_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [SIZE_W-1:0] cfg_wr_data,
  imm_in_if.sink            in_ch,
  imm_out_if.source         out_ch
);

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int CMP_W  = (DIM_W > SIZE_W) ? DIM_W : SIZE_W;

  localparam logic [CMP_W-1:0]  MaxDimC  = CMP_W'(MAX_DIM);
  localparam logic [ADDR_W-1:0] RowStep  = ADDR_W'(MAX_DIM);

  state_t state, state_next;

  logic [SIZE_W-1:0]          size_in_use;
  logic [CMP_W-1:0]           dim;
  logic [CMP_W-1:0]           cnt;
  logic [ADDR_W-1:0]          left_addr;
  logic [ADDR_W-1:0]          right_addr;
  logic [ADDR_W-1:0]          wr_addr;
  logic                       bad;
  logic                       accept;
  logic                       is_compute;
  logic                       bad_now;
  logic                       wr_in_range;
  logic                       we_left;
  logic                       we_right;
  logic                       out_load;
  logic                       last;
  logic [ELEM_BITS-1:0]       elem_in;
  logic signed [ELEM_BITS-1:0] left_q;
  logic signed [ELEM_BITS-1:0] right_q;
  logic signed [PRODUCT_W-1:0] acc;
  logic                       mac_busy;
  mac_ctrl_t                  mac_ctrl;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      size_in_use <= SIZE_RESET;
    end else if (cfg_wr_en) begin
      size_in_use <= cfg_wr_data;
    end
  end

  assign dim = (CMP_W'(size_in_use) > MaxDimC) ? MaxDimC : CMP_W'(size_in_use);

  // input decode
  assign accept      = in_ch.valid & in_ch.ready;
  assign is_compute  = (in_ch.mode == MODE_COMPUTE);
  assign bad_now     = (CMP_W'(in_ch.row) >= dim) | (CMP_W'(in_ch.col) >= dim);
  assign wr_in_range = (CMP_W'(in_ch.row) < MaxDimC) & (CMP_W'(in_ch.col) < MaxDimC);
  assign wr_addr     = ADDR_W'(in_ch.row) * RowStep + ADDR_W'(in_ch.col);
  assign elem_in     = ELEM_BITS'(in_ch.value);
  assign we_left     = accept & wr_in_range & (in_ch.mode == MODE_WR_LEFT);
  assign we_right    = accept & wr_in_range & (in_ch.mode == MODE_WR_RIGHT);
  assign last        = (cnt == dim - CMP_W'(1));

  imm_ram #(.WIDTH(ELEM_BITS), .DEPTH(DEPTH)) u_left (
    .clk   (clk),
    .we    (we_left),
    .waddr (wr_addr),
    .wdata (elem_in),
    .raddr (left_addr),
    .rdata (left_q)
  );

  imm_ram #(.WIDTH(ELEM_BITS), .DEPTH(DEPTH)) u_right (
    .clk   (clk),
    .we    (we_right),
    .waddr (wr_addr),
    .wdata (elem_in),
    .raddr (right_addr),
    .rdata (right_q)
  );

  imm_mac #(.ELEM_BITS(ELEM_BITS)) u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctrl (mac_ctrl),
    .a    (left_q),
    .b    (right_q),
    .acc  (acc),
    .busy (mac_busy)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && is_compute) begin
          state_next = bad_now ? ST_DONE : ST_RUN;
        end
      end
      ST_RUN: begin
        if (last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!mac_busy) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_ch.valid || out_ch.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready    = 1'b0;
    mac_ctrl.clear = 1'b0;
    mac_ctrl.issue = 1'b0;
    out_load       = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ch.ready    = 1'b1;
        mac_ctrl.clear = in_ch.valid & is_compute;
      end
      ST_RUN:   mac_ctrl.issue = 1'b1;
      ST_DRAIN: ;
      ST_DONE:  out_load = ~out_ch.valid | out_ch.ready;
      default:  ;
    endcase
  end

  // address walk: row of left store steps by one, column of right store by a row
  always_ff @(posedge clk) begin
    if (accept && is_compute) begin
      left_addr  <= ADDR_W'(in_ch.row) * RowStep;
      right_addr <= ADDR_W'(in_ch.col);
      cnt        <= '0;
      bad        <= bad_now;
    end else if (state == ST_RUN) begin
      left_addr  <= left_addr + ADDR_W'(1);
      right_addr <= right_addr + RowStep;
      cnt        <= cnt + CMP_W'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (out_load) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ch.product   <= bad ? '0 : acc;
      out_ch.bad_index <= bad;
    end
  end

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.bad_index |-> out_ch.product == '0)
    else $error("bad index result carries a nonzero product");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_RUN |-> cnt < dim)
    else $error("element counter ran past the dimension in use");

  a_done_idle_mac: assert property (@(posedge clk) disable iff (rst)
    state == ST_DONE |-> !mac_busy)
    else $error("result loaded while MAC still has terms in flight");

  a_good_runs: assert property (@(posedge clk) disable iff (rst)
    accept && is_compute && !bad_now |=> state == ST_RUN)
    else $error("valid compute item did not start the sequencer");

  a_no_write_busy: assert property (@(posedge clk) disable iff (rst)
    (we_left || we_right) |-> state == ST_IDLE && !mac_busy)
    else $error("store written while a dot product is running");

endmodule

>>> sv/imm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module imm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/imm_mac.sv
// Shared multiply-accumulate unit: one product term per cycle into a 32-bit sum.
module imm_mac import imm_pkg::*; #(
  parameter int ELEM_BITS = ELEM_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  mac_ctrl_t                   ctrl,
  input  logic signed [ELEM_BITS-1:0] a,
  input  logic signed [ELEM_BITS-1:0] b,
  output logic signed [PRODUCT_W-1:0] acc,
  output logic                        busy
);

  logic                        data_v;
  logic                        prod_v;
  logic signed [PRODUCT_W-1:0] a_ext;
  logic signed [PRODUCT_W-1:0] b_ext;
  logic signed [PRODUCT_W-1:0] prod;

  assign a_ext = PRODUCT_W'(a);
  assign b_ext = PRODUCT_W'(b);
  assign busy  = data_v | prod_v;

  // RAM data shows up in the cycle after the address is issued
  always_ff @(posedge clk) begin
    if (rst) begin
      data_v <= 1'b0;
      prod_v <= 1'b0;
    end else begin
      data_v <= ctrl.issue;
      prod_v <= data_v;
    end
  end

  // low 32 bits of the product are all the wrapped sum needs
  always_ff @(posedge clk) begin
    if (data_v) begin
      prod <= a_ext * b_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc <= '0;
    end else if (prod_v) begin
      acc <= acc + prod;
    end
  end

endmodule

>>> verif/tb_top.sv
// Self-checking testbench for the integer matrix multiply engine.
`timescale 1ns / 100ps

module tb_top;
  import imm_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int IDLE_CYCLES = 80;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic signed [PRODUCT_W-1:0] product;
    logic                        bad_index;
  } product_t;

  logic                clk;
  logic                rst;
  logic                cfg_wr_en;
  logic [SIZE_W-1:0]   cfg_wr_data;

  imm_in_if  in_if ();
  imm_out_if out_if ();

  integer_matrix_multiply_engine dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_if),
    .out_ch      (out_if)
  );

  // Predictor state: element stores, written flags and the size register.
  logic signed [VALUE_W-1:0] left_mat  [MAX_DIM_DEF][MAX_DIM_DEF];
  logic signed [VALUE_W-1:0] right_mat [MAX_DIM_DEF][MAX_DIM_DEF];
  bit                        left_set  [MAX_DIM_DEF][MAX_DIM_DEF];
  bit                        right_set [MAX_DIM_DEF][MAX_DIM_DEF];
  logic [SIZE_W-1:0]         size_reg = SIZE_RESET;

  product_t pending_products[$];
  int       mismatch_count = 0;
  int       items_sent = 0;
  int       burst_left = 0;
  int       hold_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic int active_dim();
    return (size_reg > MAX_DIM_DEF) ? MAX_DIM_DEF : int'(size_reg);
  endfunction

  function automatic product_t predict_entry(input int r, input int c);
    product_t                    res;
    logic signed [PRODUCT_W-1:0] term;
    logic [PRODUCT_W-1:0]        acc;
    int                          dim;
    int                          k;
    dim = active_dim();
    res.product   = '0;
    res.bad_index = 1'b1;
    if (r < dim && c < dim) begin
      acc = '0;
      for (k = 0; k < dim; k++) begin
        term = left_mat[r][k] * right_mat[k][c];
        acc  = acc + term;
      end
      res.product   = acc;
      res.bad_index = 1'b0;
    end
    return res;
  endfunction

  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return '0;
      3: return '1;
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  // Offer one item in bursts with random gaps; update the predictor on acceptance.
  task automatic send_item(input logic [MODE_W-1:0] md, input int r, input int c,
                           input logic signed [VALUE_W-1:0] v);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      repeat (gap) begin
        @(negedge clk);
        in_if.valid <= 1'b0;
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    in_if.valid <= 1'b1;
    in_if.mode  <= md;
    in_if.row   <= ROW_W'(r);
    in_if.col   <= COL_W'(c);
    in_if.value <= v;
    do @(posedge clk); while (!in_if.ready);
    case (md)
      MODE_WR_LEFT: begin
        left_mat[r][c] = v;
        left_set[r][c] = 1'b1;
      end
      MODE_WR_RIGHT: begin
        right_mat[r][c] = v;
        right_set[r][c] = 1'b1;
      end
      MODE_COMPUTE: pending_products.insert(pending_products.size(), predict_entry(r, c));
      default: ;
    endcase
    if (md != MODE_UNUSED)
      items_sent++;
  endtask

  // Sender pauses until every result is back and the block has gone quiet.
  task automatic wait_for_idle();
    @(negedge clk);
    in_if.valid <= 1'b0;
    burst_left = 0;
    while (pending_products.size() != 0)
      @(posedge clk);
    repeat (IDLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_size(input logic [SIZE_W-1:0] sz);
    wait_for_idle();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= sz;
    @(posedge clk);
    size_reg = sz;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Load whatever of row r of A and column c of B is still unwritten, then ask for C[r][c].
  task automatic request_entry(input int r, input int c);
    int dim;
    int k;
    dim = active_dim();
    for (k = 0; k < dim; k++) begin
      if (!left_set[r][k])
        send_item(MODE_WR_LEFT, r, k, pick_value());
      if (!right_set[k][c])
        send_item(MODE_WR_RIGHT, k, c, pick_value());
    end
    send_item(MODE_COMPUTE, r, c, pick_value());
  endtask

  task automatic test_extreme_elements();
    set_size(7'd2);
    send_item(MODE_WR_LEFT, 0, 0, 16'sh8000);
    send_item(MODE_WR_LEFT, 0, 1, 16'sh8000);
    send_item(MODE_WR_RIGHT, 0, 0, 16'sh8000);
    send_item(MODE_WR_RIGHT, 1, 0, 16'sh8000);
    send_item(MODE_COMPUTE, 0, 0, '0);      // 2 * 2^30 wraps to the most negative sum
    send_item(MODE_WR_LEFT, 1, 0, 16'sh7FFF);
    send_item(MODE_WR_LEFT, 1, 1, '1);
    send_item(MODE_WR_RIGHT, 0, 1, 16'sh7FFF);
    send_item(MODE_WR_RIGHT, 1, 1, '0);
    send_item(MODE_COMPUTE, 1, 1, '1);
    send_item(MODE_COMPUTE, 0, 1, 16'sh7FFF);
    send_item(MODE_COMPUTE, 1, 0, 16'sh8000);
    send_item(MODE_WR_LEFT, 63, 63, 16'sh7FFF);
    send_item(MODE_WR_RIGHT, 63, 63, '1);
    set_size(7'd1);
    send_item(MODE_COMPUTE, 0, 0, '0);
  endtask

  task automatic test_bad_index();
    send_item(MODE_COMPUTE, 1, 0, '0);
    send_item(MODE_COMPUTE, 0, 1, '0);
    set_size(7'd0);                          // nothing is in range at size zero
    send_item(MODE_COMPUTE, 0, 0, '0);
    set_size(7'd2);
    send_item(MODE_COMPUTE, 63, 63, '0);
    send_item(MODE_COMPUTE, 2, 1, '0);
    send_item(MODE_COMPUTE, 1, 63, '0);
  endtask

  task automatic test_unused_mode();
    send_item(MODE_UNUSED, 63, 63, '1);
    send_item(MODE_UNUSED, 0, 0, 16'sh7FFF);
    send_item(MODE_COMPUTE, 0, 0, '0);
    send_item(MODE_COMPUTE, 1, 1, '0);
  endtask

  // Result side holds off long enough that the block backs up into its input.
  task automatic test_output_backpressure();
    int n;
    set_size(7'd4);
    @(posedge clk);
    hold_cycles = 400;
    for (n = 0; n < 12; n++)
      request_entry($urandom_range(0, 3), $urandom_range(0, 3));
  endtask

  task automatic run_random_phase(input logic [SIZE_W-1:0] sz, input int budget);
    int stop_at;
    int dim;
    int pick;
    int r;
    int c;
    set_size(sz);
    dim = active_dim();
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        send_item(($urandom_range(0, 1) != 0) ? MODE_WR_RIGHT : MODE_WR_LEFT,
                  $urandom_range(0, 63), $urandom_range(0, 63), pick_value());
      end else if (pick < 23) begin
        send_item(MODE_UNUSED, $urandom_range(0, 63), $urandom_range(0, 63), pick_value());
      end else if (dim == 0 || (pick < 35 && dim < MAX_DIM_DEF)) begin
        r = $urandom_range(0, 63);
        c = $urandom_range(0, 63);
        if (dim != 0) begin
          if ($urandom_range(0, 1) != 0)
            r = $urandom_range(dim, 63);
          else
            c = $urandom_range(dim, 63);
        end
        send_item(MODE_COMPUTE, r, c, pick_value());
      end else begin
        // large sizes mostly revisit a few rows and columns to keep fills short
        r = (dim > 8 && $urandom_range(0, 4) != 0) ? $urandom_range(0, 3)
                                                   : $urandom_range(0, dim - 1);
        c = (dim > 8 && $urandom_range(0, 4) != 0) ? $urandom_range(0, 3)
                                                   : $urandom_range(0, dim - 1);
        request_entry(r, c);
      end
    end
  endtask

  task automatic test_random_sizes();
    run_random_phase(7'd64, 180);
    run_random_phase(7'd1, 30);
    run_random_phase(7'd2, 40);
    run_random_phase(7'd5, 50);
    run_random_phase(SIZE_W'($urandom_range(3, 16)), 60);
    run_random_phase(7'd127, 60);           // saturates to the full dimension
    run_random_phase(7'd0, 20);
    run_random_phase(SIZE_W'($urandom_range(65, 126)), 40);
    run_random_phase(7'd8, 50);
  endtask

  // Result side: ready follows a rotating stall pattern, or a long requested hold-off.
  initial begin : result_sink
    logic [15:0] stall_pat;
    int          pat_age;
    out_if.ready = 1'b0;
    stall_pat = '1;
    pat_age = 0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_if.ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_if.ready <= stall_pat[0];
        stall_pat = {stall_pat[0], stall_pat[15:1]};
        pat_age++;
        if (pat_age == 48) begin
          pat_age = 0;
          stall_pat = ($urandom_range(0, 2) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0101);
        end
      end
    end
  end

  always @(posedge clk) begin : check_results
    product_t want;
    if (!rst && out_if.valid && out_if.ready) begin
      if (pending_products.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("%0t: unexpected item product=%0d bad_index=%0b", $realtime,
                   out_if.product, out_if.bad_index);
      end else begin
        want = pending_products.pop_front();
        if (out_if.product !== want.product || out_if.bad_index !== want.bad_index) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: mismatch product exp=%0d act=%0d bad_index exp=%0b act=%0b",
                     $realtime, want.product, out_if.product, want.bad_index,
                     out_if.bad_index);
        end
      end
    end
  end

  initial begin
    rst          = 1'b1;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = SIZE_RESET;
    in_if.valid  = 1'b0;
    in_if.mode   = MODE_WR_LEFT;
    in_if.row    = '0;
    in_if.col    = '0;
    in_if.value  = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_extreme_elements();
    test_bad_index();
    test_unused_mode();
    test_output_backpressure();
    test_random_sizes();
    wait_for_idle();
    if (mismatch_count == 0 && pending_products.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

>>> sim.f
sv/imm_pkg.sv
sv/imm_if.sv
sv/imm_ram.sv
sv/imm_mac.sv
sv/integer_matrix_multiply_engine.sv
verif/tb_top.sv
